// ----- src/saoeo_pkg.sv -----
`timescale 1ns / 1ps

package saoeo_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int DIFF_W      = 23;
  localparam int SUM_W       = DIFF_W + 1;
  localparam int CNT_W       = 13;
  localparam int NUM_DIRS    = 3;
  localparam int NUM_CATS    = 4;
  localparam int NUM_TOTALS  = NUM_DIRS * NUM_CATS;
  localparam int POS_W       = $clog2(NUM_TOTALS);
  localparam int DIR_W       = 2;
  localparam int CAT_W       = 2;

  // sign weights of one neighbor against the center
  localparam logic [1:0] SGN_LESS    = 2'd0;
  localparam logic [1:0] SGN_EQUAL   = 2'd1;
  localparam logic [1:0] SGN_GREATER = 2'd2;

  // edge categories
  localparam logic [CAT_W-1:0] CAT_LOCAL_MIN = 2'd0;
  localparam logic [CAT_W-1:0] CAT_CORNER_LO = 2'd1;
  localparam logic [CAT_W-1:0] CAT_CORNER_HI = 2'd2;
  localparam logic [CAT_W-1:0] CAT_LOCAL_MAX = 2'd3;

  // first edge class code on the result channel (vertical)
  localparam logic [DIR_W-1:0] DIR_VERTICAL = 2'd1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic             hit;
    logic [CAT_W-1:0] cat;
  } class_t;

endpackage

// ----- src/saoeo_in_if.sv -----
`timescale 1ns / 1ps

interface saoeo_in_if;
  logic                 valid;
  logic                 ready;
  saoeo_pkg::sample_t   source_sample;
  saoeo_pkg::sample_t   center_recon;
  saoeo_pkg::sample_t   above_recon;
  saoeo_pkg::sample_t   below_recon;
  saoeo_pkg::sample_t   above_left_recon;
  saoeo_pkg::sample_t   below_right_recon;
  saoeo_pkg::sample_t   above_right_recon;
  saoeo_pkg::sample_t   below_left_recon;
  logic                 last_sample;

  modport source (
    output valid, source_sample, center_recon, above_recon, below_recon,
           above_left_recon, below_right_recon, above_right_recon,
           below_left_recon, last_sample,
    input  ready
  );

  modport sink (
    input  valid, source_sample, center_recon, above_recon, below_recon,
           above_left_recon, below_right_recon, above_right_recon,
           below_left_recon, last_sample,
    output ready
  );
endinterface

// ----- src/saoeo_out_if.sv -----
`timescale 1ns / 1ps

interface saoeo_out_if;
  logic                               valid;
  logic                               ready;
  logic [saoeo_pkg::DIR_W-1:0]        direction;
  logic [saoeo_pkg::CAT_W-1:0]        category;
  logic signed [saoeo_pkg::DIFF_W-1:0] diff_sum;
  logic [saoeo_pkg::CNT_W-1:0]        sample_count;
  logic                               last_total;

  modport source (
    output valid, direction, category, diff_sum, sample_count, last_total,
    input  ready
  );

  modport sink (
    input  valid, direction, category, diff_sum, sample_count, last_total,
    output ready
  );
endinterface

// ----- src/sao_edge_offset_stats.sv -----
`timescale 1ns / 1ps

// SAO edge-offset statistics for the vertical, 135-degree and 45-degree
// classes. in_s carries one interior sample per beat: source, center recon
// and the six neighbors. Each beat is registered, then classified per
// direction, and the source-minus-recon difference and a count are added
// into 12 saturating accumulators. in_s takes one beat per cycle unless a
// last_sample beat is held; the accumulator update is a combinational
// compare and add. A beat with last_sample set snapshots the 12 totals
// into a drain buffer and clears the accumulators in the same cycle.
// The first total passes the drain buffer and the output register to out_m,
// then one total per cycle while out_m is ready, in order direction 1..3,
// category 0..3; the twelfth carries last_total. The drain buffer holds one
// set of totals: a new last_sample beat waits in the input register while
// the previous set is still draining, and earlier samples keep flowing. A
// stalled out_m holds its beat and, through the drain buffer, eventually
// the input side. Reset (synchronous, active low) clears the accumulators,
// the drain state and both valid flags.
module sao_edge_offset_stats (
  input  logic              clk,
  input  logic              rst_n,
  saoeo_in_if.sink          in_s,
  saoeo_out_if.source       out_m
);

  localparam int DW = saoeo_pkg::SAMPLE_BITS + 1;

  // input register
  logic                       s1_valid_r;
  logic                       s1_last_r;
  saoeo_pkg::sample_t         s1_src_r;
  saoeo_pkg::sample_t         s1_ctr_r;
  saoeo_pkg::sample_t         s1_nba_r [saoeo_pkg::NUM_DIRS];
  saoeo_pkg::sample_t         s1_nbb_r [saoeo_pkg::NUM_DIRS];

  // accumulators and drain buffer
  saoeo_pkg::diff_t           acc_diff_r [saoeo_pkg::NUM_TOTALS];
  saoeo_pkg::cnt_t            acc_cnt_r  [saoeo_pkg::NUM_TOTALS];
  saoeo_pkg::diff_t           acc_diff_nxt [saoeo_pkg::NUM_TOTALS];
  saoeo_pkg::cnt_t            acc_cnt_nxt  [saoeo_pkg::NUM_TOTALS];
  saoeo_pkg::diff_t           upd_diff [saoeo_pkg::NUM_TOTALS];
  saoeo_pkg::cnt_t            upd_cnt  [saoeo_pkg::NUM_TOTALS];
  saoeo_pkg::diff_t           snap_diff_r [saoeo_pkg::NUM_TOTALS];
  saoeo_pkg::cnt_t            snap_cnt_r  [saoeo_pkg::NUM_TOTALS];
  logic                       emit_busy_r;
  logic [saoeo_pkg::POS_W-1:0] emit_pos_r;

  // output register
  logic                       out_valid_r;
  logic [saoeo_pkg::DIR_W-1:0] out_dir_r;
  logic [saoeo_pkg::CAT_W-1:0] out_cat_r;
  saoeo_pkg::diff_t           out_diff_r;
  saoeo_pkg::cnt_t            out_cnt_r;
  logic                       out_last_r;

  logic                       s1_adv;
  logic                       in_take;
  logic                       snap_take;
  logic                       out_load;
  logic signed [DW-1:0]       diff;
  saoeo_pkg::class_t          cls [saoeo_pkg::NUM_DIRS];

  function automatic logic [1:0] sign_weight(saoeo_pkg::sample_t nb,
                                             saoeo_pkg::sample_t ctr);
    logic [1:0] w;
    if (nb > ctr) begin
      w = saoeo_pkg::SGN_GREATER;
    end else if (nb == ctr) begin
      w = saoeo_pkg::SGN_EQUAL;
    end else begin
      w = saoeo_pkg::SGN_LESS;
    end
    return w;
  endfunction

  function automatic saoeo_pkg::class_t classify(saoeo_pkg::sample_t a,
                                                 saoeo_pkg::sample_t b,
                                                 saoeo_pkg::sample_t ctr);
    saoeo_pkg::class_t c;
    logic [2:0]        s;
    s     = {1'b0, sign_weight(a, ctr)} + {1'b0, sign_weight(b, ctr)};
    c.hit = 1'b1;
    c.cat = saoeo_pkg::CAT_LOCAL_MIN;
    case (s)
      3'd4:    c.cat = saoeo_pkg::CAT_LOCAL_MIN;
      3'd3:    c.cat = saoeo_pkg::CAT_CORNER_LO;
      3'd1:    c.cat = saoeo_pkg::CAT_CORNER_HI;
      3'd0:    c.cat = saoeo_pkg::CAT_LOCAL_MAX;
      default: c.hit = 1'b0;
    endcase
    return c;
  endfunction

  // add with saturation to the diff_t range
  function automatic saoeo_pkg::diff_t sat_add(saoeo_pkg::diff_t acc,
                                               logic signed [DW-1:0] d);
    logic signed [saoeo_pkg::SUM_W-1:0] sum;
    saoeo_pkg::diff_t                   r;
    sum = {acc[saoeo_pkg::DIFF_W-1], acc}
        + {{(saoeo_pkg::SUM_W-DW){d[DW-1]}}, d};
    if (sum[saoeo_pkg::SUM_W-1] == sum[saoeo_pkg::SUM_W-2]) begin
      r = sum[saoeo_pkg::DIFF_W-1:0];
    end else if (sum[saoeo_pkg::SUM_W-1]) begin
      r = {1'b1, {(saoeo_pkg::DIFF_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(saoeo_pkg::DIFF_W-1){1'b1}}};
    end
    return r;
  endfunction

  // hold a last beat while the previous totals still drain
  assign s1_adv    = s1_valid_r && !(s1_last_r && emit_busy_r);
  assign in_s.ready = !s1_valid_r || s1_adv;
  assign in_take   = in_s.valid && in_s.ready;
  assign snap_take = s1_adv && s1_last_r;
  assign out_load  = emit_busy_r && (!out_valid_r || out_m.ready);

  assign diff = $signed({1'b0, s1_src_r}) - $signed({1'b0, s1_ctr_r});

  always_comb begin
    for (int d = 0; d < saoeo_pkg::NUM_DIRS; d++) begin
      cls[d] = classify(s1_nba_r[d], s1_nbb_r[d], s1_ctr_r);
    end
  end

  always_comb begin
    for (int i = 0; i < saoeo_pkg::NUM_TOTALS; i++) begin
      upd_diff[i] = acc_diff_r[i];
      upd_cnt[i]  = acc_cnt_r[i];
      if (s1_adv && cls[i / saoeo_pkg::NUM_CATS].hit &&
          cls[i / saoeo_pkg::NUM_CATS].cat ==
            saoeo_pkg::CAT_W'(i % saoeo_pkg::NUM_CATS)) begin
        upd_diff[i] = sat_add(acc_diff_r[i], diff);
        if (acc_cnt_r[i] != saoeo_pkg::CNT_MAX) begin
          upd_cnt[i] = acc_cnt_r[i] + saoeo_pkg::CNT_W'(1);
        end
      end
      if (snap_take) begin
        acc_diff_nxt[i] = '0;
        acc_cnt_nxt[i]  = '0;
      end else begin
        acc_diff_nxt[i] = upd_diff[i];
        acc_cnt_nxt[i]  = upd_cnt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_s.ready) begin
      s1_valid_r <= in_s.valid;
    end
    if (in_take) begin
      s1_last_r   <= in_s.last_sample;
      s1_src_r    <= in_s.source_sample;
      s1_ctr_r    <= in_s.center_recon;
      s1_nba_r[0] <= in_s.above_recon;
      s1_nbb_r[0] <= in_s.below_recon;
      s1_nba_r[1] <= in_s.above_left_recon;
      s1_nbb_r[1] <= in_s.below_right_recon;
      s1_nba_r[2] <= in_s.above_right_recon;
      s1_nbb_r[2] <= in_s.below_left_recon;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < saoeo_pkg::NUM_TOTALS; i++) begin
        acc_diff_r[i] <= '0;
        acc_cnt_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < saoeo_pkg::NUM_TOTALS; i++) begin
        acc_diff_r[i] <= acc_diff_nxt[i];
        acc_cnt_r[i]  <= acc_cnt_nxt[i];
      end
    end
  end

  // drain buffer: load on a last beat, shift toward entry 0 per output beat
  always_ff @(posedge clk) begin
    if (snap_take) begin
      for (int i = 0; i < saoeo_pkg::NUM_TOTALS; i++) begin
        snap_diff_r[i] <= upd_diff[i];
        snap_cnt_r[i]  <= upd_cnt[i];
      end
    end else if (out_load) begin
      for (int i = 0; i < saoeo_pkg::NUM_TOTALS - 1; i++) begin
        snap_diff_r[i] <= snap_diff_r[i+1];
        snap_cnt_r[i]  <= snap_cnt_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_busy_r <= 1'b0;
      emit_pos_r  <= '0;
    end else if (snap_take) begin
      emit_busy_r <= 1'b1;
      emit_pos_r  <= '0;
    end else if (out_load) begin
      if (emit_pos_r == saoeo_pkg::POS_W'(saoeo_pkg::NUM_TOTALS - 1)) begin
        emit_busy_r <= 1'b0;
        emit_pos_r  <= '0;
      end else begin
        emit_pos_r  <= emit_pos_r + saoeo_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_dir_r  <= saoeo_pkg::DIR_VERTICAL
                  + saoeo_pkg::DIR_W'(emit_pos_r / saoeo_pkg::NUM_CATS);
      out_cat_r  <= saoeo_pkg::CAT_W'(emit_pos_r % saoeo_pkg::NUM_CATS);
      out_diff_r <= snap_diff_r[0];
      out_cnt_r  <= snap_cnt_r[0];
      out_last_r <= (emit_pos_r == saoeo_pkg::POS_W'(saoeo_pkg::NUM_TOTALS - 1));
    end
  end

  assign out_m.valid        = out_valid_r;
  assign out_m.direction    = out_dir_r;
  assign out_m.category     = out_cat_r;
  assign out_m.diff_sum     = out_diff_r;
  assign out_m.sample_count = out_cnt_r;
  assign out_m.last_total   = out_last_r;

endmodule

// ----- tb/sao_edge_offset_stats_tb.sv -----
`timescale 1ns / 1ps

module sao_edge_offset_stats_tb;

  localparam int SAMPLE_MAX     = (1 << saoeo_pkg::SAMPLE_BITS) - 1;
  localparam int SUM_HI         = (1 << (saoeo_pkg::DIFF_W - 1)) - 1;
  localparam int SUM_LO         = -(1 << (saoeo_pkg::DIFF_W - 1));
  localparam int RANDOM_SAMPLES = 360;
  localparam int HOLD_AFTER     = 150;
  localparam int HOLD_CYCLES    = 400;
  localparam int RISE_SAMPLES   = 24;
  localparam int FALL_SAMPLES   = 24;
  localparam int DRAIN_CYCLES   = 24;
  localparam int N_DIR_ROWS     = 12;
  localparam longint LIMIT_NS   = 64'd6_000_000;

  // weight sums of a neighbor pair
  localparam int W_BOTH_GREATER = 2 * int'(saoeo_pkg::SGN_GREATER);
  localparam int W_GREATER_EQ   = int'(saoeo_pkg::SGN_GREATER) + int'(saoeo_pkg::SGN_EQUAL);
  localparam int W_LESS_EQ      = int'(saoeo_pkg::SGN_LESS) + int'(saoeo_pkg::SGN_EQUAL);
  localparam int W_BOTH_LESS    = 2 * int'(saoeo_pkg::SGN_LESS);

  // category per direction, with an extra code for an unclassified sample
  localparam logic [2:0] NO_CAT = 3'b100;
  localparam logic [2:0] K_MIN  = {1'b0, saoeo_pkg::CAT_LOCAL_MIN};
  localparam logic [2:0] K_LO   = {1'b0, saoeo_pkg::CAT_CORNER_LO};
  localparam logic [2:0] K_HI   = {1'b0, saoeo_pkg::CAT_CORNER_HI};
  localparam logic [2:0] K_MAX  = {1'b0, saoeo_pkg::CAT_LOCAL_MAX};

  typedef struct {
    saoeo_pkg::sample_t source_sample;
    saoeo_pkg::sample_t center_recon;
    saoeo_pkg::sample_t above_recon;
    saoeo_pkg::sample_t below_recon;
    saoeo_pkg::sample_t above_left_recon;
    saoeo_pkg::sample_t below_right_recon;
    saoeo_pkg::sample_t above_right_recon;
    saoeo_pkg::sample_t below_left_recon;
    logic               last_sample;
  } sample_beat_t;

  typedef struct packed {
    logic [saoeo_pkg::DIR_W-1:0] direction;
    logic [saoeo_pkg::CAT_W-1:0] category;
    saoeo_pkg::diff_t            diff_sum;
    saoeo_pkg::cnt_t             sample_count;
    logic                        last_total;
  } stat_total_t;

  typedef struct {
    sample_beat_t beat;
    bit           typed;
    int           typed_diff;
    logic [2:0]   k_vert;
    logic [2:0]   k_d135;
    logic [2:0]   k_d45;
  } dir_row_t;

  // some single-sample blocks carry their totals typed in; the rest go through the predictor
  dir_row_t dir_rows [N_DIR_ROWS] = '{
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 1'b1}, 1'b1, 0, NO_CAT, NO_CAT, NO_CAT},
    '{'{1023, 0, 1023, 1023, 1023, 1023, 1023, 1023, 1'b1}, 1'b1, 1023, K_MIN, K_MIN, K_MIN},
    '{'{0, 1023, 0, 0, 0, 0, 0, 0, 1'b1}, 1'b1, -1023, K_MAX, K_MAX, K_MAX},
    '{'{700, 512, 513, 512, 511, 512, 600, 400, 1'b1}, 1'b1, 188, K_LO, K_HI, NO_CAT},
    '{'{100, 512, 512, 513, 512, 511, 400, 600, 1'b1}, 1'b1, -412, K_LO, K_HI, NO_CAT},
    '{'{1023, 1023, 1023, 0, 0, 1023, 1023, 1023, 1'b0}, 1'b0, 0, NO_CAT, NO_CAT, NO_CAT},
    '{'{0, 0, 0, 1, 1, 0, 1, 1, 1'b0}, 1'b0, 0, NO_CAT, NO_CAT, NO_CAT},
    '{'{511, 512, 1023, 0, 0, 1023, 513, 511, 1'b0}, 1'b0, 0, NO_CAT, NO_CAT, NO_CAT},
    '{'{1023, 0, 1, 2, 1023, 1023, 0, 0, 1'b0}, 1'b0, 0, NO_CAT, NO_CAT, NO_CAT},
    '{'{0, 1023, 1022, 1021, 0, 1, 1023, 1022, 1'b1}, 1'b0, 0, NO_CAT, NO_CAT, NO_CAT},
    '{'{300, 200, 250, 150, 199, 199, 201, 200, 1'b1}, 1'b0, 0, NO_CAT, NO_CAT, NO_CAT},
    '{'{5, 1000, 1001, 1001, 999, 1000, 1000, 1000, 1'b1}, 1'b0, 0, NO_CAT, NO_CAT, NO_CAT}
  };

  logic clk = 1'b0;
  logic rst_n;

  saoeo_in_if  in_if ();
  saoeo_out_if out_if ();

  sao_edge_offset_stats dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_m (out_if)
  );

  always #6 clk = ~clk;

  int          class_sum [saoeo_pkg::NUM_TOTALS];
  int          class_cnt [saoeo_pkg::NUM_TOTALS];
  stat_total_t totals_q [$];
  int          mismatches;
  int          samples_sent;
  int          blocks_sent;
  int          totals_taken;

  function automatic int sign_weight(saoeo_pkg::sample_t nb, saoeo_pkg::sample_t ctr);
    if (nb > ctr) return int'(saoeo_pkg::SGN_GREATER);
    if (nb == ctr) return int'(saoeo_pkg::SGN_EQUAL);
    return int'(saoeo_pkg::SGN_LESS);
  endfunction

  function automatic logic [2:0] edge_class(saoeo_pkg::sample_t a, saoeo_pkg::sample_t b,
                                            saoeo_pkg::sample_t ctr);
    case (sign_weight(a, ctr) + sign_weight(b, ctr))
      W_BOTH_GREATER: return K_MIN;
      W_GREATER_EQ:   return K_LO;
      W_LESS_EQ:      return K_HI;
      W_BOTH_LESS:    return K_MAX;
      default:        return NO_CAT;
    endcase
  endfunction

  // Add one sample into the class totals; on the last sample queue the 12 totals and clear.
  task automatic tally_sample(input sample_beat_t b, input bit emit);
    logic [2:0]  cls [saoeo_pkg::NUM_DIRS];
    int          d, s, v;
    stat_total_t t;
    d = int'(b.source_sample) - int'(b.center_recon);
    cls[0] = edge_class(b.above_recon, b.below_recon, b.center_recon);
    cls[1] = edge_class(b.above_left_recon, b.below_right_recon, b.center_recon);
    cls[2] = edge_class(b.above_right_recon, b.below_left_recon, b.center_recon);
    for (int k = 0; k < saoeo_pkg::NUM_DIRS; k++) begin
      if (cls[k] != NO_CAT) begin
        s = k * saoeo_pkg::NUM_CATS + int'(cls[k][saoeo_pkg::CAT_W-1:0]);
        v = class_sum[s] + d;
        if (v > SUM_HI) v = SUM_HI;
        if (v < SUM_LO) v = SUM_LO;
        class_sum[s] = v;
        if (class_cnt[s] < int'(saoeo_pkg::CNT_MAX)) class_cnt[s]++;
      end
    end
    if (b.last_sample) begin
      blocks_sent++;
      for (int k = 0; k < saoeo_pkg::NUM_TOTALS; k++) begin
        t.direction    = saoeo_pkg::DIR_VERTICAL
                       + saoeo_pkg::DIR_W'(k / saoeo_pkg::NUM_CATS);
        t.category     = saoeo_pkg::CAT_W'(k % saoeo_pkg::NUM_CATS);
        t.diff_sum     = saoeo_pkg::diff_t'(class_sum[k]);
        t.sample_count = saoeo_pkg::cnt_t'(class_cnt[k]);
        t.last_total   = (k == saoeo_pkg::NUM_TOTALS - 1);
        if (emit) totals_q.push_back(t);
        class_sum[k] = 0;
        class_cnt[k] = 0;
      end
    end
  endtask

  // Hold valid until the beat is taken; valid stays high afterwards.
  task automatic offer_sample(input sample_beat_t b, input int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid             <= 1'b1;
    in_if.source_sample     <= b.source_sample;
    in_if.center_recon      <= b.center_recon;
    in_if.above_recon       <= b.above_recon;
    in_if.below_recon       <= b.below_recon;
    in_if.above_left_recon  <= b.above_left_recon;
    in_if.below_right_recon <= b.below_right_recon;
    in_if.above_right_recon <= b.above_right_recon;
    in_if.below_left_recon  <= b.below_left_recon;
    in_if.last_sample       <= b.last_sample;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    samples_sent++;
  endtask

  task automatic feed_sample(input sample_beat_t b, input int gap);
    offer_sample(b, gap);
    tally_sample(b, 1'b1);
  endtask

  task automatic idle_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (totals_q.size() != 0);
  endtask

  function automatic saoeo_pkg::sample_t neighbor_near(saoeo_pkg::sample_t c);
    int v;
    case ($urandom_range(0, 3))
      0:       v = int'(c);
      1:       v = int'(c) + int'($urandom_range(1, 2));
      2:       v = int'(c) - int'($urandom_range(1, 2));
      default: v = int'($urandom_range(0, SAMPLE_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return saoeo_pkg::sample_t'(v);
  endfunction

  function automatic sample_beat_t random_beat(bit last);
    sample_beat_t b;
    case ($urandom_range(0, 7))
      0:       b.center_recon = '0;
      1:       b.center_recon = saoeo_pkg::sample_t'(SAMPLE_MAX);
      default: b.center_recon = saoeo_pkg::sample_t'($urandom_range(0, SAMPLE_MAX));
    endcase
    if ($urandom_range(0, 7) == 0)
      b.source_sample = $urandom_range(0, 1) ? saoeo_pkg::sample_t'(SAMPLE_MAX) : '0;
    else
      b.source_sample = saoeo_pkg::sample_t'($urandom_range(0, SAMPLE_MAX));
    b.above_recon       = neighbor_near(b.center_recon);
    b.below_recon       = neighbor_near(b.center_recon);
    b.above_left_recon  = neighbor_near(b.center_recon);
    b.below_right_recon = neighbor_near(b.center_recon);
    b.above_right_recon = neighbor_near(b.center_recon);
    b.below_left_recon  = neighbor_near(b.center_recon);
    b.last_sample       = last;
    return b;
  endfunction

  // Local minimum with a large positive difference, or local maximum with a
  // large negative one.
  function automatic sample_beat_t skewed_beat(bit rising, bit last);
    sample_beat_t b;
    if (rising) begin
      b.center_recon      = saoeo_pkg::sample_t'($urandom_range(0, 15));
      b.source_sample     = saoeo_pkg::sample_t'(SAMPLE_MAX - $urandom_range(0, 15));
      b.above_recon       = saoeo_pkg::sample_t'($urandom_range(16, SAMPLE_MAX));
      b.below_recon       = saoeo_pkg::sample_t'($urandom_range(16, SAMPLE_MAX));
      b.above_left_recon  = saoeo_pkg::sample_t'($urandom_range(16, SAMPLE_MAX));
      b.below_right_recon = saoeo_pkg::sample_t'($urandom_range(16, SAMPLE_MAX));
      b.above_right_recon = saoeo_pkg::sample_t'($urandom_range(16, SAMPLE_MAX));
      b.below_left_recon  = saoeo_pkg::sample_t'($urandom_range(16, SAMPLE_MAX));
    end else begin
      b.center_recon      = saoeo_pkg::sample_t'(SAMPLE_MAX - $urandom_range(0, 15));
      b.source_sample     = saoeo_pkg::sample_t'($urandom_range(0, 15));
      b.above_recon       = saoeo_pkg::sample_t'($urandom_range(0, SAMPLE_MAX - 16));
      b.below_recon       = saoeo_pkg::sample_t'($urandom_range(0, SAMPLE_MAX - 16));
      b.above_left_recon  = saoeo_pkg::sample_t'($urandom_range(0, SAMPLE_MAX - 16));
      b.below_right_recon = saoeo_pkg::sample_t'($urandom_range(0, SAMPLE_MAX - 16));
      b.above_right_recon = saoeo_pkg::sample_t'($urandom_range(0, SAMPLE_MAX - 16));
      b.below_left_recon  = saoeo_pkg::sample_t'($urandom_range(0, SAMPLE_MAX - 16));
    end
    b.last_sample = last;
    return b;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  initial begin : result_sink
    stat_total_t got, want;
    int          stall;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      // every 64 beats, run 16 with no stall
      stall = ((totals_taken % 64) < 16) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got.direction    = out_if.direction;
      got.category     = out_if.category;
      got.diff_sum     = out_if.diff_sum;
      got.sample_count = out_if.sample_count;
      got.last_total   = out_if.last_total;
      totals_taken++;
      if (totals_q.size() == 0) begin
        $display("%0t: unexpected total: direction %0d category %0d diff_sum %0d count %0d",
                 $time, got.direction, got.category, $signed(got.diff_sum),
                 got.sample_count);
        mismatches++;
      end else begin
        want = totals_q.pop_front();
        check_field("direction", int'(want.direction), int'(got.direction));
        check_field("category", int'(want.category), int'(got.category));
        check_field("diff_sum", int'($signed(want.diff_sum)), int'($signed(got.diff_sum)));
        check_field("sample_count", int'(want.sample_count), int'(got.sample_count));
        check_field("last_total", int'(want.last_total), int'(got.last_total));
      end
      // long hold-off: lets the drain buffer fill and back up the input
      if (totals_taken == HOLD_AFTER) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin : sample_source
    int           n, k, blk_len, total_skewed;
    bit           burst, paused;
    logic [2:0]   kc;
    stat_total_t  t;
    rst_n                   <= 1'b0;
    in_if.valid             <= 1'b0;
    in_if.source_sample     <= '0;
    in_if.center_recon      <= '0;
    in_if.above_recon       <= '0;
    in_if.below_recon       <= '0;
    in_if.above_left_recon  <= '0;
    in_if.below_right_recon <= '0;
    in_if.above_right_recon <= '0;
    in_if.below_left_recon  <= '0;
    in_if.last_sample       <= 1'b0;
    for (k = 0; k < saoeo_pkg::NUM_TOTALS; k++) begin
      class_sum[k] = 0;
      class_cnt[k] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < N_DIR_ROWS; n++) begin
      offer_sample(dir_rows[n].beat, $urandom_range(0, 8));
      tally_sample(dir_rows[n].beat, !dir_rows[n].typed);
      if (dir_rows[n].typed) begin
        for (k = 0; k < saoeo_pkg::NUM_TOTALS; k++) begin
          case (k / saoeo_pkg::NUM_CATS)
            0:       kc = dir_rows[n].k_vert;
            1:       kc = dir_rows[n].k_d135;
            default: kc = dir_rows[n].k_d45;
          endcase
          t.direction    = saoeo_pkg::DIR_VERTICAL
                         + saoeo_pkg::DIR_W'(k / saoeo_pkg::NUM_CATS);
          t.category     = saoeo_pkg::CAT_W'(k % saoeo_pkg::NUM_CATS);
          t.diff_sum     = (kc == {1'b0, t.category}) ?
                           saoeo_pkg::diff_t'(dir_rows[n].typed_diff) : '0;
          t.sample_count = (kc == {1'b0, t.category}) ? saoeo_pkg::cnt_t'(1) : '0;
          t.last_total   = (k == saoeo_pkg::NUM_TOTALS - 1);
          totals_q.push_back(t);
        end
      end
    end

    n = 0;
    paused = 1'b0;
    while (n < RANDOM_SAMPLES) begin
      blk_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 20);
      burst   = ($urandom_range(0, 3) == 0);
      for (k = 0; k < blk_len; k++) begin
        feed_sample(random_beat(k == blk_len - 1), burst ? 0 : $urandom_range(0, 8));
        n++;
      end
      if (!paused && n >= RANDOM_SAMPLES / 2) begin
        idle_until_drained();
        paused = 1'b1;
      end
    end

    // one block of strong local minima, then strong local maxima, back to back
    total_skewed = RISE_SAMPLES + FALL_SAMPLES;
    for (n = 0; n < total_skewed; n++)
      feed_sample(skewed_beat(n < RISE_SAMPLES, n == total_skewed - 1), 0);

    idle_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d samples in %0d blocks, checked %0d totals;", samples_sent,
             blocks_sent, totals_taken);
    $display("all categories, back-to-back block ends, output hold-off and large sums seen.");
    if (mismatches == 0)
      $display("sao_edge_offset_stats verification clean");
    else
      $display("sao_edge_offset_stats verification failed");
    $finish;
  end

  initial begin : run_limit
    #(LIMIT_NS);
    $display("%0t: run limit reached", $time);
    $display("sao_edge_offset_stats verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/saoeo_pkg.sv
src/saoeo_in_if.sv
src/saoeo_out_if.sv
src/sao_edge_offset_stats.sv
tb/sao_edge_offset_stats_tb.sv
